// ===== src/ctt_pkg.sv =====
// ----------------------------------------------------------------------------
// ctt_pkg
// Shared widths and constants for the circle-through-three-points pipeline.
// ----------------------------------------------------------------------------
package ctt_pkg;

  localparam int CoordW = 16;
  localparam int InDataW = 6 * CoordW;
  localparam int OutW = 32;
  localparam int OutDataW = 104;

  // divider: numerator 2|n| + 2|det|, divisor 4|det|
  localparam int DivNumW = 54;
  localparam int DivDenW = 37;

  // square root of a 64-bit radicand
  localparam int SqrtRadW = 64;
  localparam int SqrtRootW = 32;

  // output field positions
  localparam int OutCcwBit = 96;
  localparam int OutDegBit = 97;
  localparam int OutSatBit = 98;

endpackage

// ===== src/ctt_div.sv =====
// ----------------------------------------------------------------------------
// ctt_div
// Pipelined restoring divider, one quotient bit per stage, with side band.
// ----------------------------------------------------------------------------
module ctt_div #(
  parameter int NW = 54,
  parameter int DW = 37,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic [NW-1:0] en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic [NW-1:0] quo,
  output logic [SW-1:0] side_out
);

  logic [DW-1:0] rem  [NW];
  logic [NW-1:0] acc  [NW];
  logic [DW-1:0] dreg [NW];
  logic [SW-1:0] side [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DW-1:0] rem_i;
    logic [NW-1:0] acc_i;
    logic [DW-1:0] d_i;
    logic [SW-1:0] side_i;
    logic [DW:0]   t;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_i  = '0;
      assign acc_i  = num;
      assign d_i    = den;
      assign side_i = side_in;
    end else begin : g_next
      assign rem_i  = rem[k-1];
      assign acc_i  = acc[k-1];
      assign d_i    = dreg[k-1];
      assign side_i = side[k-1];
    end

    assign t  = {rem_i, acc_i[NW-1]};
    assign ge = t >= {1'b0, d_i};

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem[k]  <= ge ? DW'(t - {1'b0, d_i}) : t[DW-1:0];
        acc[k]  <= {acc_i[NW-2:0], ge};
        dreg[k] <= d_i;
        side[k] <= side_i;
      end
    end
  end

  assign quo      = acc[NW-1];
  assign side_out = side[NW-1];

endmodule

// ===== src/ctt_sqrt.sv =====
// ----------------------------------------------------------------------------
// ctt_sqrt
// Pipelined integer square root, one root bit per stage; gives root and
// remainder (radicand - root^2).
// ----------------------------------------------------------------------------
module ctt_sqrt #(
  parameter int RW = 64,
  parameter int QW = 32,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic [QW-1:0] en,
  input  logic [RW-1:0] rad,
  input  logic [SW-1:0] side_in,
  output logic [QW-1:0] root,
  output logic [QW+1:0] rem_out,
  output logic [SW-1:0] side_out
);

  logic [RW-1:0] radr [QW];
  logic [QW-1:0] rt   [QW];
  logic [QW+1:0] rem  [QW];
  logic [SW-1:0] side [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [RW-1:0] rad_i;
    logic [QW-1:0] rt_i;
    logic [QW+1:0] rem_i;
    logic [SW-1:0] side_i;
    logic [QW+3:0] t;
    logic [QW+3:0] trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign rad_i  = rad;
      assign rt_i   = '0;
      assign rem_i  = '0;
      assign side_i = side_in;
    end else begin : g_next
      assign rad_i  = radr[k-1];
      assign rt_i   = rt[k-1];
      assign rem_i  = rem[k-1];
      assign side_i = side[k-1];
    end

    assign t     = {rem_i, rad_i[RW-1:RW-2]};
    assign trial = {2'b00, rt_i, 2'b01};
    assign ge    = t >= trial;

    always_ff @(posedge clk) begin
      if (en[k]) begin
        radr[k] <= {rad_i[RW-3:0], 2'b00};
        rt[k]   <= {rt_i[QW-2:0], ge};
        rem[k]  <= ge ? (QW+2)'(t - trial) : t[QW+1:0];
        side[k] <= side_i;
      end
    end
  end

  assign root     = rt[QW-1];
  assign rem_out  = rem[QW-1];
  assign side_out = side[QW-1];

endmodule

// ===== src/circle_through_three_points_top.sv =====
// ----------------------------------------------------------------------------
// circle_through_three_points_top
// Circumcircle of three Q12.4 points: center, radius, turn, flags.
//
//  channel | dir | beat
//  s_*     | in  | three points
//  m_*     | out | center, radius, flags
//
// One beat per cycle sustained while m_tready stays high. Stages: 7 front
// stages, 54-stage divider, 3 stages, 32-stage square root, output register.
// Every stage has its own valid bit and advances when empty or when the
// stage after it advances, so bubbles close up under stall.
// Reset clears the valid bits only.
// ----------------------------------------------------------------------------
module circle_through_three_points_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // first_x, first_y, second_x, second_y, third_x, third_y
  input  logic [ctt_pkg::InDataW-1:0]  s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // center_x, center_y, radius, counter_clockwise, degenerate, saturated, pad
  output logic [ctt_pkg::OutDataW-1:0] m_tdata
);
  import ctt_pkg::*;

  localparam int DivN = DivNumW;
  localparam int SqN  = SqrtRootW;
  localparam int PDiv = 7;
  localparam int PPost = PDiv + DivN;
  localparam int PSq  = PPost + 3;
  localparam int NSt  = PSq + SqN + 1;

  logic [NSt-1:0] v;
  logic [NSt-1:0] v_next;
  logic [NSt-1:0] en;

  always_comb begin
    en[NSt-1] = !v[NSt-1] || m_tready;
    for (int i = NSt - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  always_comb begin
    v_next = v;
    if (en[0]) begin
      v_next[0] = s_tvalid;
    end
    for (int i = 1; i < NSt; i++) begin
      if (en[i]) begin
        v_next[i] = v[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= v_next;
    end
  end

  assign s_tready = en[0];

  // stage 0: input register
  logic signed [15:0] p1x, p1y, p2x, p2y, p3x, p3y;
  always_ff @(posedge clk) begin
    if (en[0]) begin
      p1x <= s_tdata[15:0];
      p1y <= s_tdata[31:16];
      p2x <= s_tdata[47:32];
      p2y <= s_tdata[63:48];
      p3x <= s_tdata[79:64];
      p3y <= s_tdata[95:80];
    end
  end

  // stage 1: edge vectors
  logic signed [16:0] ax, ay, bx, by;
  logic signed [15:0] x1a, y1a;
  always_ff @(posedge clk) begin
    if (en[1]) begin
      ax  <= 17'(p2x) - 17'(p1x);
      ay  <= 17'(p2y) - 17'(p1y);
      bx  <= 17'(p3x) - 17'(p1x);
      by  <= 17'(p3y) - 17'(p1y);
      x1a <= p1x;
      y1a <= p1y;
    end
  end

  // stage 2: products
  logic signed [33:0] m_axby, m_aybx, m_axax, m_ayay, m_bxbx, m_byby;
  logic signed [16:0] ax2, ay2, bx2, by2;
  logic signed [15:0] x1b, y1b;
  always_ff @(posedge clk) begin
    if (en[2]) begin
      m_axby <= ax * by;
      m_aybx <= ay * bx;
      m_axax <= ax * ax;
      m_ayay <= ay * ay;
      m_bxbx <= bx * bx;
      m_byby <= by * by;
      ax2 <= ax; ay2 <= ay; bx2 <= bx; by2 <= by;
      x1b <= x1a; y1b <= y1a;
    end
  end

  // stage 3: determinant and squared lengths
  logic signed [34:0] det3, la, lb;
  logic signed [16:0] ax3, ay3, bx3, by3;
  logic signed [15:0] x1c, y1c;
  always_ff @(posedge clk) begin
    if (en[3]) begin
      det3 <= 35'(m_axby) - 35'(m_aybx);
      la   <= 35'(m_axax) + 35'(m_ayay);
      lb   <= 35'(m_bxbx) + 35'(m_byby);
      ax3 <= ax2; ay3 <= ay2; bx3 <= bx2; by3 <= by2;
      x1c <= x1b; y1c <= y1b;
    end
  end

  // stage 4: numerator products
  logic signed [51:0] m_byla, m_aylb, m_axlb, m_bxla;
  logic signed [34:0] det4;
  logic signed [15:0] x1d, y1d;
  always_ff @(posedge clk) begin
    if (en[4]) begin
      m_byla <= by3 * la;
      m_aylb <= ay3 * lb;
      m_axlb <= ax3 * lb;
      m_bxla <= bx3 * la;
      det4 <= det3;
      x1d <= x1c; y1d <= y1c;
    end
  end

  // stage 5: numerators
  logic signed [52:0] nx, ny;
  logic signed [34:0] det5;
  logic signed [15:0] x1e, y1e;
  always_ff @(posedge clk) begin
    if (en[5]) begin
      nx <= 53'(m_byla) - 53'(m_aylb);
      ny <= 53'(m_axlb) - 53'(m_bxla);
      det5 <= det4;
      x1e <= x1d; y1e <= y1d;
    end
  end

  // stage 6: magnitudes for rounded division
  logic [52:0] anx, any, adet;
  assign anx  = nx[52] ? 53'(-nx) : 53'(nx);
  assign any  = ny[52] ? 53'(-ny) : 53'(ny);
  assign adet = det5[34] ? 53'(-det5) : 53'(det5);

  logic [DivNumW-1:0] numx, numy;
  logic [DivDenW-1:0] den6;
  logic               negx, negy, deg6, ccw6;
  logic signed [15:0] x1f, y1f;
  always_ff @(posedge clk) begin
    if (en[6]) begin
      numx <= {anx, 1'b0} + {adet, 1'b0};
      numy <= {any, 1'b0} + {adet, 1'b0};
      den6 <= {adet[34:0], 2'b00};
      negx <= nx[52] ^ det5[34];
      negy <= ny[52] ^ det5[34];
      deg6 <= det5 == '0;
      ccw6 <= !det5[34] && det5 != '0;
      x1f <= x1e; y1f <= y1e;
    end
  end

  localparam int DSideW = 2 * CoordW + 3;
  logic [DivNumW-1:0] qx, qy;
  logic [DSideW-1:0]  dside;
  logic               negy_d;

  ctt_div #(.NW(DivNumW), .DW(DivDenW), .SW(DSideW)) u_divx (
    .clk      (clk),
    .en       (en[PDiv +: DivN]),
    .num      (numx),
    .den      (den6),
    .side_in  ({x1f, y1f, negx, deg6, ccw6}),
    .quo      (qx),
    .side_out (dside)
  );

  ctt_div #(.NW(DivNumW), .DW(DivDenW), .SW(1)) u_divy (
    .clk      (clk),
    .en       (en[PDiv +: DivN]),
    .num      (numy),
    .den      (den6),
    .side_in  (negy),
    .quo      (qy),
    .side_out (negy_d)
  );

  // post stage 0: centers, clamp, magnitudes
  logic signed [15:0] x1g, y1g;
  logic               negx_d, deg_d, ccw_d;
  assign {x1g, y1g, negx_d, deg_d, ccw_d} = dside;

  logic signed [55:0] cxw, cyw;
  assign cxw = 56'(x1g) + (negx_d ? -56'(qx) : 56'(qx));
  assign cyw = 56'(y1g) + (negy_d ? -56'(qy) : 56'(qy));

  logic cx_ovf, cy_ovf;
  assign cx_ovf = !((&cxw[55:31]) || !(|cxw[55:31]));
  assign cy_ovf = !((&cyw[55:31]) || !(|cyw[55:31]));

  logic [OutW-1:0] cx7, cy7, mx7, my7;
  logic            csat7, rovf7, deg7, ccw7;
  always_ff @(posedge clk) begin
    if (en[PPost]) begin
      cx7   <= cx_ovf ? {cxw[55], {(OutW-1){!cxw[55]}}} : cxw[OutW-1:0];
      cy7   <= cy_ovf ? {cyw[55], {(OutW-1){!cyw[55]}}} : cyw[OutW-1:0];
      csat7 <= cx_ovf || cy_ovf;
      rovf7 <= (|qx[DivNumW-1:OutW]) || (|qy[DivNumW-1:OutW]);
      mx7   <= qx[OutW-1:0];
      my7   <= qy[OutW-1:0];
      deg7  <= deg_d;
      ccw7  <= ccw_d;
    end
  end

  // post stage 1: squares
  logic [63:0]     sx8, sy8;
  logic [OutW-1:0] cx8, cy8;
  logic            csat8, rovf8, deg8, ccw8;
  always_ff @(posedge clk) begin
    if (en[PPost+1]) begin
      sx8 <= mx7 * mx7;
      sy8 <= my7 * my7;
      cx8 <= cx7; cy8 <= cy7;
      csat8 <= csat7; rovf8 <= rovf7; deg8 <= deg7; ccw8 <= ccw7;
    end
  end

  // post stage 2: sum of squares
  logic [64:0]     sum_w;
  assign sum_w = {1'b0, sx8} + {1'b0, sy8};

  logic [SqrtRadW-1:0] sum9;
  logic [OutW-1:0]     cx9, cy9;
  logic                csat9, rovf9, deg9, ccw9;
  always_ff @(posedge clk) begin
    if (en[PPost+2]) begin
      sum9  <= sum_w[63:0];
      rovf9 <= rovf8 || sum_w[64];
      cx9 <= cx8; cy9 <= cy8;
      csat9 <= csat8; deg9 <= deg8; ccw9 <= ccw8;
    end
  end

  localparam int SSideW = 2 * OutW + 4;
  logic [SqrtRootW-1:0] root;
  logic [SqrtRootW+1:0] srem;
  logic [SSideW-1:0]    sside;

  ctt_sqrt #(.RW(SqrtRadW), .QW(SqrtRootW), .SW(SSideW)) u_sqrt (
    .clk      (clk),
    .en       (en[PSq +: SqN]),
    .rad      (sum9),
    .side_in  ({cx9, cy9, csat9, rovf9, deg9, ccw9}),
    .root     (root),
    .rem_out  (srem),
    .side_out (sside)
  );

  // output stage: round radius to nearest, assemble beat
  logic [OutW-1:0] cx_s, cy_s;
  logic            csat_s, rovf_s, deg_s, ccw_s;
  assign {cx_s, cy_s, csat_s, rovf_s, deg_s, ccw_s} = sside;

  logic [OutW:0] r_w;
  logic          rsat;
  assign r_w  = (srem > {2'b00, root}) ? {1'b0, root} + 1'b1 : {1'b0, root};
  assign rsat = rovf_s || r_w[OutW];

  logic [OutDataW-1:0] m_tdata_next;
  always_comb begin
    m_tdata_next = '0;
    if (deg_s) begin
      m_tdata_next[OutDegBit] = 1'b1;
    end else begin
      m_tdata_next[OutW-1:0]        = cx_s;
      m_tdata_next[2*OutW-1:OutW]   = cy_s;
      m_tdata_next[3*OutW-1:2*OutW] = rsat ? '1 : r_w[OutW-1:0];
      m_tdata_next[OutCcwBit]       = ccw_s;
      m_tdata_next[OutSatBit]       = csat_s || rsat;
    end
  end

  always_ff @(posedge clk) begin
    if (en[NSt-1]) begin
      m_tdata <= m_tdata_next;
    end
  end

  assign m_tvalid = v[NSt-1];

endmodule

// ===== src/ctt_checker.sv =====
// ----------------------------------------------------------------------------
// ctt_checker
// Port-level assertions for the circumcircle pipeline, bound to the top.
// ----------------------------------------------------------------------------
module ctt_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tready,
  input logic [ctt_pkg::OutDataW-1:0] m_tdata,
  input logic                         m_tvalid,
  input logic                         m_tready
);
  import ctt_pkg::*;

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("output beat valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output beat changed");

  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[OutDegBit] |->
      m_tdata[OutCcwBit-1:0] == '0 && !m_tdata[OutCcwBit] && !m_tdata[OutSatBit])
    else $error("collinear beat carries nonzero results");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output stage");

endmodule

bind circle_through_three_points_top ctt_checker u_ctt_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tdata  (m_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);

// ===== tb/tb_circle_through_three_points_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_circle_through_three_points_top
// Self-checking bench for the circumcircle pipeline. Point triples go in on
// the s_* stream, and each triple's circle is predicted with 64-bit integer
// math. Results on m_* are compared with the predictions in order. Both sides
// throttle at random, and one long output stall backs the pipeline up.
// ----------------------------------------------------------------------------
module tb_circle_through_three_points_top;
  import ctt_pkg::*;

  typedef struct packed {
    logic [31:0] cx;
    logic [31:0] cy;
    logic [31:0] rad;
    logic        ccw;
    logic        deg;
    logic        sat;
  } circle_t;

  class circle_board;
    circle_t pending_q[$];
    int      errors = 0;

    static function automatic longint unsigned root_floor(longint unsigned s);
      longint unsigned res, t;
      res = 0;
      for (int b = 31; b >= 0; b--) begin
        t = res | (64'd1 << b);
        if (t * t <= s) res = t;
      end
      return res;
    endfunction

    // quotient rounded to nearest, ties away from zero
    static function automatic longint round_div(longint n, longint d);
      longint unsigned an, ad, q;
      an = (n < 0) ? -n : n;
      ad = (d < 0) ? -d : d;
      q = (2 * an + ad) / (2 * ad);
      return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
    endfunction

    static function automatic longint clip32(longint v, ref bit sat);
      if (v > 64'sd2147483647) begin sat = 1; return 64'sd2147483647; end
      if (v < -64'sd2147483648) begin sat = 1; return -64'sd2147483648; end
      return v;
    endfunction

    static function automatic circle_t circle_of(logic [InDataW-1:0] d);
      circle_t c;
      longint x1, y1, ax, ay, bx, by, det, la, lb, nx, ny, ux, uy;
      longint unsigned mx, my, f, r;
      logic [64:0] sq;
      bit sat;
      x1 = longint'($signed(d[15:0]));
      y1 = longint'($signed(d[31:16]));
      ax = longint'($signed(d[47:32])) - x1;
      ay = longint'($signed(d[63:48])) - y1;
      bx = longint'($signed(d[79:64])) - x1;
      by = longint'($signed(d[95:80])) - y1;
      det = ax * by - ay * bx;
      c = '0;
      if (det == 0) begin
        c.deg = 1;
        return c;
      end
      sat = 0;
      la = ax * ax + ay * ay;
      lb = bx * bx + by * by;
      nx = by * la - ay * lb;
      ny = ax * lb - bx * la;
      ux = round_div(nx, 2 * det);
      uy = round_div(ny, 2 * det);
      c.cx = 32'(clip32(x1 + ux, sat));
      c.cy = 32'(clip32(y1 + uy, sat));
      mx = (ux < 0) ? -ux : ux;
      my = (uy < 0) ? -uy : uy;
      if (mx > 64'hFFFF_FFFF || my > 64'hFFFF_FFFF) begin
        r = 64'hFFFF_FFFF;
        sat = 1;
      end else begin
        sq = 65'(mx * mx) + 65'(my * my);
        if (sq[64]) begin
          r = 64'hFFFF_FFFF;
          sat = 1;
        end else begin
          f = root_floor(sq[63:0]);
          r = (f * f + f < sq[63:0]) ? f + 1 : f;
          if (r > 64'hFFFF_FFFF) begin r = 64'hFFFF_FFFF; sat = 1; end
        end
      end
      c.rad = r[31:0];
      c.ccw = det > 0;
      c.sat = sat;
      return c;
    endfunction

    function void note(logic [InDataW-1:0] d);
      pending_q.insert(pending_q.size(), circle_of(d));
    endfunction

    function void check(logic [OutDataW-1:0] t);
      circle_t e;
      if (pending_q.size() == 0) begin
        $error("unexpected result beat %h", t);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (t[31:0] !== e.cx) begin
        $error("center_x exp %0d got %0d", $signed(e.cx), $signed(t[31:0])); errors++;
      end
      if (t[63:32] !== e.cy) begin
        $error("center_y exp %0d got %0d", $signed(e.cy), $signed(t[63:32])); errors++;
      end
      if (t[95:64] !== e.rad) begin
        $error("radius exp %0d got %0d", e.rad, t[95:64]); errors++;
      end
      if (t[OutCcwBit] !== e.ccw) begin
        $error("counter_clockwise exp %0b got %0b", e.ccw, t[OutCcwBit]); errors++;
      end
      if (t[OutDegBit] !== e.deg) begin
        $error("degenerate exp %0b got %0b", e.deg, t[OutDegBit]); errors++;
      end
      if (t[OutSatBit] !== e.sat) begin
        $error("saturated exp %0b got %0b", e.sat, t[OutSatBit]); errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata;
  logic                m_tvalid;
  logic                m_tready;
  logic [OutDataW-1:0] m_tdata;

  circle_board board;
  int  tx_idle;
  int  rx_idle;
  bit  rx_hold;
  bit  hold_go;
  int  cycles;

  circle_through_three_points_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 500000) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) m_tready <= 0;
    else m_tready <= !rx_hold && ($urandom_range(99) >= rx_idle);
  end

  // long output stall so the pipeline fills and s_tready drops
  initial begin
    rx_hold = 0;
    wait (hold_go);
    @(posedge clk);
    rx_hold = 1;
    repeat (400) @(posedge clk);
    rx_hold = 0;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check(m_tdata);
  end

  function automatic logic [15:0] clamp16(int v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return 16'(v);
  endfunction

  function automatic logic [InDataW-1:0] pts(int x1, int y1, int x2, int y2,
                                             int x3, int y3);
    return {clamp16(y3), clamp16(x3), clamp16(y2), clamp16(x2),
            clamp16(y1), clamp16(x1)};
  endfunction

  function automatic int rnd(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic logic [InDataW-1:0] random_triple();
    int x1, y1, dx, dy, k, m, span;
    x1 = rnd(-32768, 32767);
    y1 = rnd(-32768, 32767);
    case ($urandom_range(5))
      0: return {$urandom, $urandom, $urandom};
      1: begin
        span = 1 << $urandom_range(10);
        return pts(x1, y1, x1 + rnd(-span, span), y1 + rnd(-span, span),
                   x1 + rnd(-span, span), y1 + rnd(-span, span));
      end
      2: begin
        dx = rnd(-300, 300); dy = rnd(-300, 300);
        k = rnd(-40, 40); m = rnd(-40, 40);
        x1 = rnd(-16000, 16000); y1 = rnd(-16000, 16000);
        return pts(x1, y1, x1 + k * dx, y1 + k * dy, x1 + m * dx, y1 + m * dy);
      end
      3: begin
        dx = rnd(-300, 300); dy = rnd(-300, 300);
        k = rnd(-50, 50); m = rnd(-50, 50);
        x1 = rnd(-16000, 16000); y1 = rnd(-16000, 16000);
        return pts(x1, y1, x1 + k * dx, y1 + k * dy,
                   x1 + m * dx + rnd(-1, 1), y1 + m * dy + rnd(-1, 1));
      end
      4: begin
        dx = rnd(-32768, 32767); dy = rnd(-32768, 32767);
        return ($urandom_range(1)) ? pts(x1, y1, x1, y1, dx, dy)
                                   : pts(x1, y1, dx, dy, dx, dy);
      end
      default: return pts(rnd(-64, 64), rnd(-64, 64), rnd(-64, 64),
                          rnd(-64, 64), rnd(-64, 64), rnd(-64, 64));
    endcase
  endfunction

  task automatic send(logic [InDataW-1:0] d);
    while ($urandom_range(99) < tx_idle) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata  <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note(d);
  endtask

  logic [InDataW-1:0] directed_q[$];

  initial begin
    board    = new();
    rst      = 1;
    s_tvalid = 0;
    s_tdata  = '0;
    hold_go  = 0;
    tx_idle  = 11;
    rx_idle  = 56;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    directed_q = '{
      pts(0, 0, 0, 0, 0, 0),
      pts(0, 0, 16, 0, 0, 16),
      pts(0, 0, 0, 16, 16, 0),
      pts(-32768, -32768, 32767, -32768, -32768, 32767),
      pts(-32768, -32768, -32768, 32767, 32767, -32768),
      pts(32767, 32767, -32768, 32767, 32767, -32768),
      pts(-32768, -32768, 0, 0, 32767, 32767),
      pts(-32768, -32768, 32767, 32767, 32767, 32766),
      pts(-32768, -32768, 32767, 32767, 32766, 32767),
      pts(-32768, 0, 32767, 1, 0, 0),
      pts(-32768, -32768, 32767, 32766, 32766, 32765),
      pts(5, 5, 5, 5, 100, -7),
      pts(1, 2, 3, 4, 1, 2),
      pts(0, 0, 1, 0, 0, 1),
      pts(0, 0, 1, 1, 2, 0),
      pts(32767, 0, -32768, 0, 0, 32767),
      pts(0, -32768, 0, 32767, 1, 0),
      pts(-32768, -32768, -32768, -32768, -32768, -32768),
      pts(32767, 32767, 32767, 32767, 32767, 32767)
    };
    foreach (directed_q[i]) send(directed_q[i]);

    repeat (530) send(random_triple());
    tx_idle = 56;
    rx_idle = 11;
    repeat (530) send(random_triple());
    tx_idle = 0;
    rx_idle = 0;
    hold_go = 1;
    repeat (530) send(random_triple());
    s_tvalid <= 0;

    while (board.pending_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (board.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
